// ----- hw/rtl/cct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compare channel timer package
// Command codes, field widths, register indexes and the control record that
// travels along the row of channel cells.
// ----------------------------------------------------------------------------
package cct_pkg;

  localparam int CMD_BITS       = 2;
  localparam int CHAN_IDX_BITS  = 3;
  localparam int CFG_IDX_BITS   = 1;

  localparam int NUM_CHANNELS_DEF = 5;
  localparam int COUNT_BITS_DEF   = 16;

  localparam logic [CMD_BITS-1:0] CMD_TICK     = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_STOP     = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_START    = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_RECHARGE = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] REG_DEFINED = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ONESHOT = 1'b1;

  // Control part of a request as it moves from cell to cell.
  typedef struct packed {
    logic                     valid;
    logic [CMD_BITS-1:0]      cmd;
    logic [CHAN_IDX_BITS-1:0] chan;
    logic                     status;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/cct_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compare channel timer stream interfaces
// Valid/ready channels for commands into the timer and results out of it.
// ----------------------------------------------------------------------------
interface cct_in_if #(
  parameter int COUNT_BITS = cct_pkg::COUNT_BITS_DEF
);
  logic                               valid;
  logic                               ready;
  logic [cct_pkg::CMD_BITS-1:0]       cmd;
  logic [cct_pkg::CHAN_IDX_BITS-1:0]  channel;
  logic [COUNT_BITS-1:0]              period;

  modport source (output valid, cmd, channel, period, input ready);
  modport sink   (input valid, cmd, channel, period, output ready);
endinterface

interface cct_out_if #(
  parameter int NUM_CHANNELS = cct_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_BITS   = cct_pkg::COUNT_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic                    status;
  logic [NUM_CHANNELS-1:0] fired_mask;
  logic [COUNT_BITS-1:0]   count_now;

  modport source (output valid, status, fired_mask, count_now, input ready);
  modport sink   (input valid, status, fired_mask, count_now, output ready);
endinterface

// ----- hw/rtl/cct_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compare channel cell
// Holds one channel's compare value, period and enable, acts on the request
// passing through and hands the request on to the next cell.
// ----------------------------------------------------------------------------
module cct_cell #(
  parameter int NUM_CHANNELS = cct_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_BITS   = cct_pkg::COUNT_BITS_DEF,
  parameter int IDX          = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    def_bit,
  input  logic                    oneshot_bit,
  input  cct_pkg::cell_ctl_t      ctl_i,
  input  logic [COUNT_BITS-1:0]   period_i,
  input  logic [COUNT_BITS-1:0]   count_i,
  input  logic [NUM_CHANNELS-1:0] fired_i,
  output cct_pkg::cell_ctl_t      ctl_o,
  output logic [COUNT_BITS-1:0]   period_o,
  output logic [COUNT_BITS-1:0]   count_o,
  output logic [NUM_CHANNELS-1:0] fired_o
);
  import cct_pkg::*;

  cell_ctl_t               ctl_r;
  logic [COUNT_BITS-1:0]   period_r;
  logic [COUNT_BITS-1:0]   count_r;
  logic [NUM_CHANNELS-1:0] fired_r, fired_nxt;

  logic                    en_r, en_nxt;
  logic [COUNT_BITS-1:0]   cmp_r, cmp_nxt;
  logic [COUNT_BITS-1:0]   per_r, per_nxt;

  logic hit;
  logic addressed;

  assign hit = ctl_i.valid && (ctl_i.cmd == CMD_TICK) && en_r && def_bit &&
               (cmp_r == count_i);
  assign addressed = ctl_i.valid && !ctl_i.status && (ctl_i.cmd != CMD_TICK) &&
                     (ctl_i.chan == CHAN_IDX_BITS'(IDX));

  always_comb begin
    en_nxt  = en_r;
    cmp_nxt = cmp_r;
    per_nxt = per_r;
    if (hit) begin
      cmp_nxt = cmp_r + per_r;
      if (oneshot_bit) begin
        en_nxt = 1'b0;
      end
    end
    if (addressed) begin
      case (ctl_i.cmd)
        CMD_STOP: begin
          en_nxt = 1'b0;
        end
        CMD_START, CMD_RECHARGE: begin
          per_nxt = period_i;
          cmp_nxt = count_i + period_i;
          en_nxt  = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    fired_nxt      = fired_i;
    fired_nxt[IDX] = fired_i[IDX] | hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
      en_r        <= 1'b0;
    end else if (adv) begin
      ctl_r <= ctl_i;
      en_r  <= en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      period_r <= period_i;
      count_r  <= count_i;
      fired_r  <= fired_nxt;
      cmp_r    <= cmp_nxt;
      per_r    <= per_nxt;
    end
  end

  assign ctl_o    = ctl_r;
  assign period_o = period_r;
  assign count_o  = count_r;
  assign fired_o  = fired_r;

endmodule

// ----- hw/rtl/compare_channel_soft_timer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compare channel soft timer
// Free-running counter with a row of compare channels, one cell per channel.
// ----------------------------------------------------------------------------
// The timer takes one request in every clock cycle that the row moves on and
// returns one result per request, in order. A request first updates the
// free-running counter at the entry, then walks down a row of NUM_CHANNELS
// cells, one cell each time the row moves on; each cell owns one channel,
// handles only its own part of the request and registers it for the next
// cell. The last cell's register is the output register, and the whole row
// moves on whenever that register is empty or its result is being taken. A
// new request is therefore accepted in the same cycle as a finished result
// is taken, but the row stands still while a finished result waits unread.
// Configuration writes are expected only while no request is in flight.
module compare_channel_soft_timer_top #(
  parameter int NUM_CHANNELS = cct_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_BITS   = cct_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  cct_in_if.sink                         in_ch,
  cct_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [cct_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [NUM_CHANNELS-1:0]        cfg_wdata
);
  import cct_pkg::*;

  // Configuration: which channels have a client, and which stop after
  // firing once.
  logic [NUM_CHANNELS-1:0] defined_r;
  logic [NUM_CHANNELS-1:0] oneshot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      defined_r <= '0;
      oneshot_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DEFINED: defined_r <= cfg_wdata;
        REG_ONESHOT: oneshot_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // The row advances when the output register can take a new result.
  logic adv;
  logic accept;
  cell_ctl_t ctl_last;

  assign adv         = !ctl_last.valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign accept      = in_ch.valid && adv;

  // Entry: a tick advances the counter, and a stop, start or recharge with a
  // channel index outside the row is flagged and then ignored by every cell.
  logic                  is_tick;
  logic                  bad_chan;
  logic [COUNT_BITS-1:0] counter_r, counter_nxt;

  assign is_tick  = (in_ch.cmd == CMD_TICK);
  assign bad_chan = !is_tick &&
                    ({1'b0, in_ch.channel} >= (CHAN_IDX_BITS + 1)'(NUM_CHANNELS));
  assign counter_nxt = is_tick ? counter_r + 1'b1 : counter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
    end else if (accept) begin
      counter_r <= counter_nxt;
    end
  end

  // Links between cells: link 0 feeds the first cell, link NUM_CHANNELS is
  // the output register of the last cell.
  cell_ctl_t               ctl_w    [NUM_CHANNELS+1];
  logic [COUNT_BITS-1:0]   period_w [NUM_CHANNELS+1];
  logic [COUNT_BITS-1:0]   count_w  [NUM_CHANNELS+1];
  logic [NUM_CHANNELS-1:0] fired_w  [NUM_CHANNELS+1];

  assign ctl_w[0] = '{valid:  in_ch.valid,
                      cmd:    in_ch.cmd,
                      chan:   in_ch.channel,
                      status: bad_chan};

  assign period_w[0] = in_ch.period;
  assign count_w[0]  = counter_nxt;
  assign fired_w[0]  = '0;

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_cell
    cct_cell #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .COUNT_BITS   (COUNT_BITS),
      .IDX          (g)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .adv         (adv),
      .def_bit     (defined_r[g]),
      .oneshot_bit (oneshot_r[g]),
      .ctl_i       (ctl_w[g]),
      .period_i    (period_w[g]),
      .count_i     (count_w[g]),
      .fired_i     (fired_w[g]),
      .ctl_o       (ctl_w[g+1]),
      .period_o    (period_w[g+1]),
      .count_o     (count_w[g+1]),
      .fired_o     (fired_w[g+1])
    );
  end

  assign ctl_last          = ctl_w[NUM_CHANNELS];
  assign out_ch.valid      = ctl_last.valid;
  assign out_ch.status     = ctl_last.status;
  assign out_ch.fired_mask = fired_w[NUM_CHANNELS];
  assign out_ch.count_now  = count_w[NUM_CHANNELS];

endmodule

// ----- verif/compare_channel_soft_timer_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compare channel soft timer testbench
// Drives timer requests through the valid/ready channels and checks every
// result against a cycle-free model of the counter and the compare channels.
// ----------------------------------------------------------------------------
// The run has several phases. Each phase programs the defined and one-shot
// masks while the timer is idle and then sends its requests. The first phase
// is directed: it covers the field extremes, every command, invalid channel
// numbers, undefined channels, one-shot channels, zero periods and restarts.
// Then come random phases under different mask settings. The sender idles in
// bursts and the receiver stalls on a changing duty pattern.
module compare_channel_soft_timer_top_test;
  import cct_pkg::*;

  localparam int NUM_CH      = NUM_CHANNELS_DEF;
  localparam int CNT_BITS    = COUNT_BITS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic [CMD_BITS-1:0]      cmd;
    logic [CHAN_IDX_BITS-1:0] channel;
    logic [CNT_BITS-1:0]      period;
  } timer_req_t;

  typedef struct packed {
    logic                status;
    logic [NUM_CH-1:0]   fired_mask;
    logic [CNT_BITS-1:0] count_now;
  } timer_report_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [NUM_CH-1:0] cfg_wdata;

  cct_in_if  #(.COUNT_BITS(CNT_BITS))                         cmd_bus ();
  cct_out_if #(.NUM_CHANNELS(NUM_CH), .COUNT_BITS(CNT_BITS)) report_bus ();

  compare_channel_soft_timer_top #(
    .NUM_CHANNELS(NUM_CH),
    .COUNT_BITS  (CNT_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (cmd_bus),
    .out_ch   (report_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // Model of the timer, updated as each request is taken.
  logic [CNT_BITS-1:0] mdl_count;
  logic [CNT_BITS-1:0] mdl_compare [NUM_CH];
  logic [CNT_BITS-1:0] mdl_reload  [NUM_CH];
  logic [NUM_CH-1:0]   mdl_enable;
  logic [NUM_CH-1:0]   mdl_defined;
  logic [NUM_CH-1:0]   mdl_oneshot;

  timer_req_t    pending_requests [$];
  timer_report_t predicted_reports [$];

  int unsigned issued_count;
  int unsigned reported_count;
  int unsigned error_count;
  int unsigned cycle_count;

  // Sender burst state and receiver stall state.
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_pct;
  int unsigned stall_span;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Applies one accepted request to the model and records the result it
  // should produce. Ticks advance the counter first and then compare every
  // channel against the new count, all channels in parallel.
  function automatic void advance_timer_model(input timer_req_t req);
    timer_report_t rep;
    rep = '0;
    if (req.cmd == CMD_TICK) begin
      mdl_count = mdl_count + 1'b1;
      for (int c = 0; c < NUM_CH; c++) begin
        if (mdl_enable[c] && mdl_defined[c] && mdl_compare[c] == mdl_count) begin
          rep.fired_mask[c] = 1'b1;
          mdl_compare[c]    = mdl_compare[c] + mdl_reload[c];
          if (mdl_oneshot[c]) mdl_enable[c] = 1'b0;
        end
      end
    end else if (req.channel >= NUM_CH) begin
      // An invalid channel number is refused and nothing changes.
      rep.status = 1'b1;
    end else if (req.cmd == CMD_STOP) begin
      mdl_enable[req.channel] = 1'b0;
    end else begin
      // Start and recharge behave alike, and simply reprogram a running
      // channel.
      mdl_reload[req.channel]  = req.period;
      mdl_compare[req.channel] = mdl_count + req.period;
      mdl_enable[req.channel]  = 1'b1;
    end
    rep.count_now = mdl_count;
    predicted_reports.push_back(rep);
  endfunction

  function automatic void flag_error(input string what, input logic [31:0] exp_val,
                                     input logic [31:0] act_val);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_val,
               act_val);
  endfunction

  // Random request, biased towards ticks and short periods so that channels
  // fire often, with occasional full-range periods and invalid channels.
  function automatic timer_req_t random_request();
    timer_req_t  req;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)      req.cmd = CMD_TICK;
    else if (pick < 65) req.cmd = CMD_STOP;
    else if (pick < 85) req.cmd = CMD_START;
    else                req.cmd = CMD_RECHARGE;
    if (req.cmd == CMD_TICK || $urandom_range(0, 99) < 8)
      req.channel = CHAN_IDX_BITS'($urandom_range(0, 7));
    else
      req.channel = CHAN_IDX_BITS'($urandom_range(0, NUM_CH - 1));
    if ($urandom_range(0, 99) < 70) req.period = CNT_BITS'($urandom_range(0, 12));
    else                            req.period = CNT_BITS'($urandom_range(0, 65535));
    return req;
  endfunction

  // Request driver: takes requests from the pending queue in bursts, with
  // random gaps between bursts. The model is advanced on each handshake.
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready)
        advance_timer_model({cmd_bus.cmd, cmd_bus.channel, cmd_bus.period});
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          cmd_bus.valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          timer_req_t req;
          req = pending_requests.pop_front();
          cmd_bus.cmd     <= req.cmd;
          cmd_bus.channel <= req.channel;
          cmd_bus.period  <= req.period;
          cmd_bus.valid   <= 1'b1;
          if (burst_left <= 1) begin
            // A fair share of bursts run back to back with no gap at all.
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result taken against the oldest prediction.
  // The receiver's duty cycle changes every so often, from never stalling to
  // stalling most of the time.
  always @(posedge clk) begin
    if (!rst_n) begin
      report_bus.ready <= 1'b0;
    end else begin
      if (report_bus.valid && report_bus.ready) begin
        reported_count++;
        if (predicted_reports.size() == 0) begin
          error_count++;
          $display("%0t: result with nothing outstanding, actual status %0h mask %0h count %0h",
                   $time, report_bus.status, report_bus.fired_mask, report_bus.count_now);
        end else begin
          timer_report_t exp_rep;
          exp_rep = predicted_reports.pop_front();
          if (report_bus.status !== exp_rep.status)
            flag_error("status", 32'(exp_rep.status), 32'(report_bus.status));
          if (report_bus.fired_mask !== exp_rep.fired_mask)
            flag_error("fired_mask", 32'(exp_rep.fired_mask), 32'(report_bus.fired_mask));
          if (report_bus.count_now !== exp_rep.count_now)
            flag_error("count_now", 32'(exp_rep.count_now), 32'(report_bus.count_now));
        end
      end
      if (stall_span == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            stall_pct <= 0;
          end
          1: begin
            stall_pct <= 20;
          end
          2: begin
            stall_pct <= 50;
          end
          default: begin
            stall_pct <= 85;
          end
        endcase
        stall_span <= $urandom_range(20, 300);
      end else begin
        stall_span <= stall_span - 1;
      end
      report_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_request(input logic [CMD_BITS-1:0] cmd,
                               input logic [CHAN_IDX_BITS-1:0] channel,
                               input logic [CNT_BITS-1:0] period);
    timer_req_t req;
    req.cmd     = cmd;
    req.channel = channel;
    req.period  = period;
    pending_requests.push_back(req);
    issued_count++;
  endtask

  task automatic queue_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      pending_requests.push_back(random_request());
      issued_count++;
    end
  endtask

  // Waits until every request has come back as a result and lets the row of cells settle.
  task automatic wait_drained();
    while (reported_count != issued_count) @(posedge clk);
    repeat (NUM_CH + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [NUM_CH-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    if (idx == REG_DEFINED) mdl_defined = val;
    else                    mdl_oneshot = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_masks(input logic [NUM_CH-1:0] defined,
                               input logic [NUM_CH-1:0] oneshot);
    write_reg(REG_DEFINED, defined);
    write_reg(REG_ONESHOT, oneshot);
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = REG_DEFINED;
    cfg_wdata        = '0;
    cmd_bus.valid    = 1'b0;
    cmd_bus.cmd      = CMD_TICK;
    cmd_bus.channel  = '0;
    cmd_bus.period   = '0;
    report_bus.ready = 1'b0;
    mdl_count        = '0;
    mdl_enable       = '0;
    mdl_defined      = '0;
    mdl_oneshot      = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      mdl_compare[c] = '0;
      mdl_reload[c]  = '0;
    end
    issued_count   = 0;
    reported_count = 0;
    error_count    = 0;
    cycle_count    = 0;
    burst_left     = 8;
    gap_left       = 0;
    stall_pct      = 0;
    stall_span     = 50;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed phase. Channel 3 is left undefined and channel 1 is one-shot.
    program_masks(5'b10111, 5'b00010);
    queue_request(CMD_TICK,     3'd7, 16'hFFFF);  // tick ignores channel and period
    queue_request(CMD_START,    3'd0, 16'd1);
    queue_request(CMD_START,    3'd1, 16'd2);
    queue_request(CMD_RECHARGE, 3'd2, 16'd0);     // zero period: fires only after a wrap
    queue_request(CMD_START,    3'd3, 16'd1);     // enabled but never reported
    queue_request(CMD_START,    3'd4, 16'hFFFF);
    queue_request(CMD_STOP,     3'd5, 16'd0);     // invalid channel numbers
    queue_request(CMD_START,    3'd6, 16'd5);
    queue_request(CMD_RECHARGE, 3'd7, 16'hFFFF);
    queue_request(CMD_TICK,     3'd0, 16'd0);
    queue_request(CMD_TICK,     3'd5, 16'h5555);
    queue_request(CMD_TICK,     3'd2, 16'hAAAA);
    queue_request(CMD_RECHARGE, 3'd0, 16'd3);     // restart of a running channel
    queue_request(CMD_STOP,     3'd4, 16'd0);
    queue_request(CMD_START,    3'd1, 16'd1);
    repeat (4) queue_request(CMD_TICK, 3'd0, 16'd0);
    queue_request(CMD_STOP,     3'd0, 16'd0);
    queue_request(CMD_STOP,     3'd1, 16'd0);
    repeat (2) queue_request(CMD_TICK, 3'd1, 16'd0);
    wait_drained();

    // Random phases under a spread of mask settings, the extremes included.
    program_masks('1, '0);
    queue_random(500);
    wait_drained();

    program_masks('1, '1);
    queue_random(500);
    wait_drained();

    program_masks('0, NUM_CH'($urandom_range(0, 31)));
    queue_random(300);
    wait_drained();

    program_masks(NUM_CH'($urandom_range(0, 31)), NUM_CH'($urandom_range(0, 31)));
    queue_random(700);
    wait_drained();

    repeat (2 * NUM_CH) @(posedge clk);
    if (error_count == 0 && predicted_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
